@@ design/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// shared types, token codes and keyword table for the source tokenizer
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int KwMaxLen = 8;
  localparam int PosBits  = 16;
  localparam int KwCount  = 46;
  localparam int WlenBits = $clog2(KwMaxLen + 2);

  // scan modes
  localparam logic [3:0] M_START    = 4'd0;
  localparam logic [3:0] M_IDENT    = 4'd1;
  localparam logic [3:0] M_NUMBER   = 4'd2;
  localparam logic [3:0] M_STRING   = 4'd3;
  localparam logic [3:0] M_ESCAPE   = 4'd4;
  localparam logic [3:0] M_LINECMT  = 4'd5;
  localparam logic [3:0] M_BLOCKCMT = 4'd6;
  localparam logic [3:0] M_OPER     = 4'd7;
  localparam logic [3:0] M_HALT     = 4'd8;

  // result kinds
  localparam logic [1:0] K_TEXT  = 2'd0;
  localparam logic [1:0] K_TOKEN = 2'd1;
  localparam logic [1:0] K_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] E_UNKNOWN = 2'd0;
  localparam logic [1:0] E_STRING  = 2'd1;
  localparam logic [1:0] E_COMMENT = 2'd2;

  // token codes
  localparam logic [6:0] T_NONE   = 7'd127;
  localparam logic [6:0] T_ARROWE = 7'd49;
  localparam logic [6:0] T_ARROW  = 7'd60;
  localparam logic [6:0] T_AND    = 7'd65;
  localparam logic [6:0] T_OR     = 7'd66;
  localparam logic [6:0] T_IDENT  = 7'd77;
  localparam logic [6:0] T_INT    = 7'd78;
  localparam logic [6:0] T_DEC    = 7'd79;
  localparam logic [6:0] T_STR    = 7'd80;
  localparam logic [6:0] T_END    = 7'd81;

  // pending operators
  localparam logic [3:0] P_NONE  = 4'd0;
  localparam logic [3:0] P_SLASH = 4'd1;
  localparam logic [3:0] P_EQ    = 4'd2;
  localparam logic [3:0] P_MINUS = 4'd7;
  localparam logic [3:0] P_AMP   = 4'd10;
  localparam logic [3:0] P_BAR   = 4'd11;

  typedef logic [PosBits-1:0] pos_t;
  typedef logic [KwMaxLen-1:0][7:0] window_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ttype;
    logic [7:0] text;
    pos_t       line;
    pos_t       col;
    logic [1:0] err;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } pair_t;

  // channel payloads
  typedef struct packed {
    logic       end_of_input;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [6:0] token_type;
    logic [7:0] text_byte;
    pos_t       start_line;
    pos_t       start_column;
    logic [1:0] error_code;
    logic       last_of_run;
  } out_item_t;

  localparam logic [7:0] KW_CHARS [KwCount][8] = '{
    '{"t","r","u","e",0,0,0,0}, '{"f","a","l","s","e",0,0,0},
    '{"m","u","t",0,0,0,0,0}, '{"c","o","n","s","t",0,0,0},
    '{"v","o","i","d",0,0,0,0}, '{"b","o","o","l",0,0,0,0},
    '{"i","n","t",0,0,0,0,0}, '{"d","o","u","b","l","e",0,0},
    '{"s","t","r","i","n","g",0,0}, '{"o","p","t","i","o","n",0,0},
    '{"r","e","s","u","l","t",0,0}, '{"a","r","r","a","y",0,0,0},
    '{"l","i","s","t",0,0,0,0}, '{"m","a","p",0,0,0,0,0},
    '{"s","e","t",0,0,0,0,0}, '{"i","f",0,0,0,0,0,0},
    '{"e","l","s","e",0,0,0,0}, '{"r","e","t","u","r","n",0,0},
    '{"m","a","t","c","h",0,0,0}, '{"f","n",0,0,0,0,0,0},
    '{"s","t","r","u","c","t",0,0}, '{"e","n","u","m",0,0,0,0},
    '{"c","o","n","t","r","a","c","t"}, '{"e","v","e","n","t",0,0,0},
    '{"s","e","r","v","i","c","e",0}, '{"s","e","r","v","e","r",0,0},
    '{"d","a","t","a","b","a","s","e"}, '{"q","u","e","r","y",0,0,0},
    '{"g","r","o","u","p",0,0,0}, '{"r","o","u","t","e",0,0,0},
    '{"p","u","b","l","i","s","h",0}, '{"c","o","n","s","u","m","e","r"},
    '{"c","l","i","e","n","t",0,0}, '{"G","E","T",0,0,0,0,0},
    '{"P","O","S","T",0,0,0,0}, '{"P","U","T",0,0,0,0,0},
    '{"D","E","L","E","T","E",0,0}, '{"P","A","T","C","H",0,0,0},
    '{"O","k",0,0,0,0,0,0}, '{"E","r","r",0,0,0,0,0},
    '{"S","o","m","e",0,0,0,0}, '{"n","u","l","l",0,0,0,0},
    '{"b","o","d","y",0,0,0,0}, '{"s","q","l",0,0,0,0,0},
    '{"p","r","i","n","t",0,0,0}, '{"a","s",0,0,0,0,0,0}
  };
  localparam logic [3:0] KW_LEN [KwCount] = '{
    4,5,3,5,4,4,3,6,6,6,6,5,4,3,3,2,4,6,5,2,6,4,8,5,7,6,8,5,5,5,7,8,6,
    3,4,3,6,5,2,3,4,4,4,3,5,2
  };

  localparam logic [7:0] OP_BYTE [12] = '{0,"/","=","!",">","<","+","-","*","%","&","|"};
  localparam logic [6:0] OP_SINGLE [12] = '{127,45,47,50,52,54,56,58,61,63,127,127};
  localparam logic [6:0] OP_WITH_EQ [12] = '{127,46,48,51,53,55,57,59,62,64,127,127};

endpackage

@@ design/sct_stream_if.sv @@
// ----------------------------------------------------------------------------
// sct_stream_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface sct_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/sct_kw_match.sv @@
// ----------------------------------------------------------------------------
// sct_kw_match
// parallel compare of the word window against the keyword table
// ----------------------------------------------------------------------------
module sct_kw_match import sct_pkg::*; (
  input  window_t             window,
  input  logic [WlenBits-1:0] wlen,
  output logic [6:0]          code
);
  logic [KwCount-1:0] hit;
  logic               eq;

  always_comb begin
    for (int i = 0; i < KwCount; i++) begin
      eq = (WlenBits'(KW_LEN[i]) == wlen);
      for (int j = 0; j < KwMaxLen; j++) begin
        if (j < 8 && j < int'(KW_LEN[i]) && window[j] != KW_CHARS[i][j % 8]) eq = 1'b0;
      end
      hit[i] = eq;
    end
    code = T_IDENT;
    for (int i = KwCount - 1; i >= 0; i--) begin
      if (hit[i]) code = (i < 2) ? 7'd0 : 7'(i - 1);
    end
  end
endmodule

@@ design/sct_scan.sv @@
// ----------------------------------------------------------------------------
// sct_scan
// next-state and result logic for one source byte
// ----------------------------------------------------------------------------
module sct_scan import sct_pkg::*; (
  input  logic [7:0]          b,
  input  logic                eoi,
  input  logic [3:0]          mode,
  input  logic [3:0]          pop,
  input  logic                dot,
  input  logic                star,
  input  window_t             window,
  input  logic [WlenBits-1:0] wlen,
  input  pos_t                cline,
  input  pos_t                ccol,
  input  pos_t                tline,
  input  pos_t                tcol,
  output logic [3:0]          mode_n,
  output logic [3:0]          pop_n,
  output logic                dot_n,
  output logic                star_n,
  output window_t             window_n,
  output logic [WlenBits-1:0] wlen_n,
  output pos_t                cline_n,
  output pos_t                ccol_n,
  output pos_t                tline_n,
  output pos_t                tcol_n,
  output logic [1:0]          cnt,
  output pair_t               res
);
  localparam pos_t PosMax = '1;

  logic [6:0] kw;
  logic       alpha, digit, space, wordc;
  logic [3:0] opidx, p;
  logic [6:0] punct;
  logic [7:0] c;
  logic [6:0] code2;
  result_t    r [2];
  logic [1:0] n;
  logic       do_start;
  pos_t       sl, sc;

  sct_kw_match u_kw (.window(window), .wlen(wlen), .code(kw));

  assign alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  assign digit = b >= "0" && b <= "9";
  assign space = b == " " || (b >= 8'd9 && b <= 8'd13);
  assign wordc = alpha || digit || b == "_";

  always_comb begin
    opidx = P_NONE;
    for (int i = 11; i >= 1; i--) if (OP_BYTE[i] == b) opidx = 4'(i);
    unique case (b)
      ".": punct = 7'd67;
      "?": punct = 7'd68;
      ":": punct = 7'd69;
      ";": punct = 7'd70;
      "{": punct = 7'd71;
      "}": punct = 7'd72;
      "(": punct = 7'd73;
      ")": punct = 7'd74;
      "[": punct = 7'd75;
      "]": punct = 7'd76;
      default: punct = T_NONE;
    endcase
  end

  function automatic result_t mk(logic [1:0] k, logic [6:0] t, logic [7:0] x,
                                 pos_t l, pos_t cc, logic [1:0] e);
    result_t o;
    o.kind = k; o.ttype = t; o.text = x; o.line = l; o.col = cc; o.err = e;
    return o;
  endfunction

  always_comb begin
    mode_n = mode; pop_n = pop; dot_n = dot; star_n = star;
    window_n = window; wlen_n = wlen;
    cline_n = cline; ccol_n = ccol; tline_n = tline; tcol_n = tcol;
    n = 2'd0;
    r[0] = '0; r[1] = '0;
    do_start = 1'b0;
    p = (pop < 4'd12) ? pop : P_NONE;
    c = OP_BYTE[p];
    code2 = T_NONE;
    sl = tline; sc = tcol;

    // byte consumption, applied when the byte is eaten
    if (!eoi && mode != M_HALT) begin
      if (b == 8'h0a) begin
        ccol_n = pos_t'(1);
        if (cline != PosMax) cline_n = cline + pos_t'(1);
      end else if (ccol != PosMax) begin
        ccol_n = ccol + pos_t'(1);
      end
    end

    if (mode == M_HALT) begin
      cline_n = cline; ccol_n = ccol;
    end else if (eoi) begin
      cline_n = cline; ccol_n = ccol;
      unique case (mode)
        M_OPER: if (OP_SINGLE[p] != T_NONE) begin
          r[n[0]] = mk(K_TOKEN, OP_SINGLE[p], 8'd0, tline, tcol, 2'd0); n = n + 2'd1;
        end
        M_IDENT: begin
          r[0] = mk(K_TOKEN, kw, 8'd0, tline, tcol, 2'd0); n = 2'd1;
        end
        M_NUMBER: begin
          r[0] = mk(K_TOKEN, dot ? T_DEC : T_INT, 8'd0, tline, tcol, 2'd0); n = 2'd1;
        end
        M_STRING, M_ESCAPE: begin
          r[0] = mk(K_ERROR, 7'd0, 8'd0, tline, tcol, E_STRING); n = 2'd1;
          mode_n = M_HALT;
        end
        M_BLOCKCMT: begin
          r[0] = mk(K_ERROR, 7'd0, 8'd0, tline, tcol, E_COMMENT); n = 2'd1;
          mode_n = M_HALT;
        end
        default: ;
      endcase
      if (mode_n != M_HALT) begin
        r[n[0]] = mk(K_TOKEN, T_END, 8'd0, cline, ccol, 2'd0);
        n = n + 2'd1;
        mode_n = M_START; pop_n = P_NONE; dot_n = 1'b0; star_n = 1'b0;
        window_n = '0; wlen_n = '0;
        cline_n = pos_t'(1); ccol_n = pos_t'(1);
        tline_n = pos_t'(1); tcol_n = pos_t'(1);
      end
    end else begin
      unique case (mode)
        M_START: do_start = 1'b1;
        M_OPER: begin
          pop_n = P_NONE; mode_n = M_START;
          if (c == "/" && b == "/") mode_n = M_LINECMT;
          else if (c == "/" && b == "*") begin
            star_n = 1'b0; mode_n = M_BLOCKCMT;
          end else begin
            if (b == "=") code2 = OP_WITH_EQ[p];
            else if (c == "=" && b == ">") code2 = T_ARROWE;
            else if (c == "-" && b == ">") code2 = T_ARROW;
            else if (c == "&" && b == "&") code2 = T_AND;
            else if (c == "|" && b == "|") code2 = T_OR;
            if (code2 != T_NONE) begin
              r[0] = mk(K_TOKEN, code2, 8'd0, tline, tcol, 2'd0); n = 2'd1;
            end else begin
              if (OP_SINGLE[p] != T_NONE) begin
                r[0] = mk(K_TOKEN, OP_SINGLE[p], 8'd0, tline, tcol, 2'd0); n = 2'd1;
              end
              do_start = 1'b1;
            end
          end
        end
        M_IDENT: if (wordc) begin
          if (wlen < WlenBits'(KwMaxLen)) window_n[wlen[WlenBits-2:0]] = b;
          if (wlen <= WlenBits'(KwMaxLen)) wlen_n = wlen + 1'b1;
          r[0] = mk(K_TEXT, 7'd0, b, tline, tcol, 2'd0); n = 2'd1;
        end else begin
          r[0] = mk(K_TOKEN, kw, 8'd0, tline, tcol, 2'd0); n = 2'd1;
          mode_n = M_START; do_start = 1'b1;
        end
        M_NUMBER: if (digit || (b == "." && !dot)) begin
          if (b == ".") dot_n = 1'b1;
          r[0] = mk(K_TEXT, 7'd0, b, tline, tcol, 2'd0); n = 2'd1;
        end else begin
          r[0] = mk(K_TOKEN, dot ? T_DEC : T_INT, 8'd0, tline, tcol, 2'd0); n = 2'd1;
          mode_n = M_START; do_start = 1'b1;
        end
        M_STRING: begin
          if (b == "\"") begin
            r[0] = mk(K_TOKEN, T_STR, 8'd0, tline, tcol, 2'd0); n = 2'd1;
            mode_n = M_START;
          end else if (b == "\\") mode_n = M_ESCAPE;
          else begin
            r[0] = mk(K_TEXT, 7'd0, b, tline, tcol, 2'd0); n = 2'd1;
          end
        end
        M_ESCAPE: begin
          r[0] = mk(K_TEXT, 7'd0, b == "n" ? 8'h0a : b == "t" ? 8'h09 :
                    b == "r" ? 8'h0d : b, tline, tcol, 2'd0);
          n = 2'd1; mode_n = M_STRING;
        end
        M_LINECMT: if (b == 8'h0a) mode_n = M_START;
        M_BLOCKCMT: begin
          if (star && b == "/") begin
            star_n = 1'b0; mode_n = M_START;
          end else star_n = (b == "*");
        end
        default: mode_n = M_HALT;
      endcase

      // start-of-token handling for the current byte
      if (do_start) begin
        tline_n = cline; tcol_n = ccol;
        sl = cline; sc = ccol;
        if (space) mode_n = M_START;
        else if (alpha || b == "_") begin
          window_n = '0; window_n[0] = b; wlen_n = WlenBits'(1);
          r[n[0]] = mk(K_TEXT, 7'd0, b, sl, sc, 2'd0); n = n + 2'd1;
          mode_n = M_IDENT;
        end else if (digit) begin
          dot_n = 1'b0;
          r[n[0]] = mk(K_TEXT, 7'd0, b, sl, sc, 2'd0); n = n + 2'd1;
          mode_n = M_NUMBER;
        end else if (b == "\"") mode_n = M_STRING;
        else if (opidx != P_NONE) begin
          pop_n = opidx; mode_n = M_OPER;
        end else if (punct != T_NONE) begin
          r[n[0]] = mk(K_TOKEN, punct, 8'd0, sl, sc, 2'd0); n = n + 2'd1;
          mode_n = M_START;
        end else begin
          r[n[0]] = mk(K_ERROR, 7'd0, 8'd0, sl, sc, E_UNKNOWN); n = n + 2'd1;
          mode_n = M_HALT;
        end
      end
    end
    cnt = n;
    res.two = (n == 2'd2);
    res.first = r[0];
    res.second = r[1];
  end
endmodule

@@ design/sct_out_buf.sv @@
// ----------------------------------------------------------------------------
// sct_out_buf
// holds up to two results of one byte and hands them out one per transfer
// ----------------------------------------------------------------------------
module sct_out_buf import sct_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  pair_t   pair,
  input  logic    has,
  output logic    free,
  output logic    valid,
  input  logic    ready,
  output result_t res,
  output logic    last
);
  logic  cnt_r, cnt_nxt;     // set while two results are left, clear with one
  logic  vld_r, vld_nxt;
  pair_t pair_r;

  assign valid = vld_r;
  assign res   = (pair_r.two && cnt_r) ? pair_r.first : pair_r.second;
  assign last  = !(pair_r.two && cnt_r);
  // accept a new pair when empty or when the final result leaves now
  assign free  = !vld_r || (ready && last);

  always_comb begin
    vld_nxt = vld_r; cnt_nxt = cnt_r;
    if (vld_r && ready) begin
      if (last) vld_nxt = 1'b0;
      else cnt_nxt = 1'b0;
    end
    if (load && has) begin
      vld_nxt = 1'b1; cnt_nxt = pair.two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0; cnt_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt; cnt_r <= cnt_nxt;
    end
    if (load && has) begin
      pair_r <= pair.two ? pair
                         : pair_t'{two: 1'b0, first: pair.second, second: pair.first};
    end
  end
endmodule

@@ design/source_code_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_code_tokenizer
// streaming maximal-munch lexer, one source byte per transfer
// ----------------------------------------------------------------------------
// latency: a byte's first result appears the cycle after its transfer
// throughput: one byte per cycle while out_ch is ready and no second result waits
// the scan state updates in the same edge as the input transfer
// reset (synchronous, rst_n low) returns to start mode at line 1, column 1
// an error halts the block until reset; halted bytes are taken and dropped
module source_code_tokenizer import sct_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  sct_stream_if.sink   in_ch,
  sct_stream_if.source out_ch
);
  // scan state
  logic [3:0]          mode_r, mode_nxt;
  logic [3:0]          pop_r, pop_nxt;
  logic                dot_r, dot_nxt, star_r, star_nxt;
  window_t             win_r, win_nxt;
  logic [WlenBits-1:0] wlen_r, wlen_nxt;
  pos_t                cline_r, cline_nxt, ccol_r, ccol_nxt;
  pos_t                tline_r, tline_nxt, tcol_r, tcol_nxt;

  logic       take, free;
  logic [1:0] cnt;
  pair_t      pair;
  result_t    res;
  logic       last;

  sct_scan u_scan (
    .b(in_ch.data.byte_value), .eoi(in_ch.data.end_of_input),
    .mode(mode_r), .pop(pop_r), .dot(dot_r), .star(star_r),
    .window(win_r), .wlen(wlen_r),
    .cline(cline_r), .ccol(ccol_r), .tline(tline_r), .tcol(tcol_r),
    .mode_n(mode_nxt), .pop_n(pop_nxt), .dot_n(dot_nxt), .star_n(star_nxt),
    .window_n(win_nxt), .wlen_n(wlen_nxt),
    .cline_n(cline_nxt), .ccol_n(ccol_nxt), .tline_n(tline_nxt), .tcol_n(tcol_nxt),
    .cnt(cnt), .res(pair)
  );

  // input transfer only when the result buffer can take this byte's results
  assign in_ch.ready = free;
  assign take        = in_ch.valid && free;

  sct_out_buf u_buf (
    .clk(clk), .rst_n(rst_n), .load(take), .pair(pair), .has(cnt != 2'd0),
    .free(free), .valid(out_ch.valid), .ready(out_ch.ready), .res(res), .last(last)
  );

  assign out_ch.data.result_kind  = res.kind;
  assign out_ch.data.token_type   = res.ttype;
  assign out_ch.data.text_byte    = res.text;
  assign out_ch.data.start_line   = res.line;
  assign out_ch.data.start_column = res.col;
  assign out_ch.data.error_code   = res.err;
  assign out_ch.data.last_of_run  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START; pop_r <= P_NONE; dot_r <= 1'b0; star_r <= 1'b0;
      win_r <= '0; wlen_r <= '0;
      cline_r <= pos_t'(1); ccol_r <= pos_t'(1);
      tline_r <= pos_t'(1); tcol_r <= pos_t'(1);
    end else if (take) begin
      mode_r <= mode_nxt; pop_r <= pop_nxt; dot_r <= dot_nxt; star_r <= star_nxt;
      win_r <= win_nxt; wlen_r <= wlen_nxt;
      cline_r <= cline_nxt; ccol_r <= ccol_nxt;
      tline_r <= tline_nxt; tcol_r <= tcol_nxt;
    end
  end
endmodule

@@ sim/tb_sct_types_pkg.sv @@
// ----------------------------------------------------------------------------
// tb_sct_types_pkg
// channel payload types shared by the tokenizer testbench modules
// ----------------------------------------------------------------------------
package tb_sct_types_pkg;
  import sct_pkg::*;

  typedef in_item_t  src_item_t;
  typedef out_item_t lex_item_t;

endpackage

@@ sim/sct_checker.sv @@
// ----------------------------------------------------------------------------
// sct_checker
// watches both tokenizer channels, predicts the lexer output and compares
// ----------------------------------------------------------------------------
module sct_checker import sct_pkg::*; import tb_sct_types_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  src_item_t in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  lex_item_t out_data,
  output int        mismatches,
  output int        awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] PosMax = 16'hFFFF;

  logic [3:0]  mode;
  logic [3:0]  pend_op;
  logic        dot_seen;
  logic        star;
  logic [7:0]  win [KwMaxLen];
  int          wlen;
  logic [15:0] cur_line, cur_col, tok_line, tok_col;

  lex_item_t lexemes_q [$];
  int        step_n;

  function automatic void clear_scan();
    mode = M_START; pend_op = P_NONE; dot_seen = 0; star = 0; wlen = 0;
    foreach (win[i]) win[i] = 8'h00;
    cur_line = 1; cur_col = 1; tok_line = 1; tok_col = 1;
  endfunction

  function automatic void push_res(logic [1:0] k, logic [6:0] t, logic [7:0] x,
                                   logic [15:0] ln, logic [15:0] cl, logic [1:0] e);
    lex_item_t it;
    it.result_kind = k; it.token_type = t; it.text_byte = x;
    it.start_line = ln; it.start_column = cl; it.error_code = e; it.last_of_run = 1'b0;
    if (step_n < 2) begin
      lexemes_q.insert(lexemes_q.size(), it);
      step_n++;
    end
  endfunction

  function automatic void push_tok(logic [6:0] t);
    push_res(K_TOKEN, t, 8'h00, tok_line, tok_col, 2'd0);
  endfunction

  function automatic void push_text(logic [7:0] x);
    push_res(K_TEXT, 7'd0, x, tok_line, tok_col, 2'd0);
  endfunction

  function automatic void advance(logic [7:0] b);
    if (b == 8'h0A) begin
      cur_col = 1;
      if (cur_line < PosMax) cur_line++;
    end else if (cur_col < PosMax) begin
      cur_col++;
    end
  endfunction

  function automatic bit alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void win_add(logic [7:0] b);
    if (wlen < KwMaxLen) win[wlen] = b;
    if (wlen <= KwMaxLen) wlen++;
  endfunction

  function automatic logic [6:0] word_code();
    bit same;
    if (wlen > KwMaxLen) return T_IDENT;
    for (int i = 0; i < KwCount; i++) begin
      if (KW_LEN[i] == wlen) begin
        same = 1;
        for (int j = 0; j < wlen; j++) if (KW_CHARS[i][j] != win[j]) same = 0;
        if (same) return (i < 2) ? 7'd0 : 7'(i - 1);
      end
    end
    return T_IDENT;
  endfunction

  function automatic void start_scan(logic [7:0] b);
    logic [6:0] code;
    code = T_NONE;
    tok_line = cur_line;
    tok_col  = cur_col;
    if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
      advance(b);
      return;
    end
    if (alpha(b) || b == "_") begin
      foreach (win[i]) win[i] = 8'h00;
      wlen = 0;
      win_add(b); push_text(b); advance(b); mode = M_IDENT;
      return;
    end
    if (digit(b)) begin
      dot_seen = 0; push_text(b); advance(b); mode = M_NUMBER;
      return;
    end
    if (b == "\"") begin
      advance(b); mode = M_STRING;
      return;
    end
    for (int i = 1; i < 12; i++) begin
      if (OP_BYTE[i] == b) begin
        advance(b); pend_op = 4'(i); mode = M_OPER;
        return;
      end
    end
    case (b)
      ".": code = 7'd67;
      "?": code = 7'd68;
      ":": code = 7'd69;
      ";": code = 7'd70;
      "{": code = 7'd71;
      "}": code = 7'd72;
      "(": code = 7'd73;
      ")": code = 7'd74;
      "[": code = 7'd75;
      "]": code = 7'd76;
      default: code = T_NONE;
    endcase
    advance(b);
    if (code != T_NONE) begin
      push_tok(code);
    end else begin
      push_res(K_ERROR, 7'd0, 8'h00, tok_line, tok_col, E_UNKNOWN);
      mode = M_HALT;
    end
  endfunction

  function automatic void oper_scan(logic [7:0] b);
    logic [3:0] p;
    logic [7:0] c;
    logic [6:0] code;
    p = (pend_op < 12) ? pend_op : P_NONE;
    c = OP_BYTE[p];
    code = T_NONE;
    pend_op = P_NONE;
    mode = M_START;
    if (c == "/" && b == "/") begin
      advance(b); mode = M_LINECMT;
      return;
    end
    if (c == "/" && b == "*") begin
      advance(b); star = 0; mode = M_BLOCKCMT;
      return;
    end
    if (b == "=") code = OP_WITH_EQ[p];
    else if (c == "=" && b == ">") code = T_ARROWE;
    else if (c == "-" && b == ">") code = T_ARROW;
    else if (c == "&" && b == "&") code = T_AND;
    else if (c == "|" && b == "|") code = T_OR;
    if (code != T_NONE) begin
      advance(b); push_tok(code);
      return;
    end
    if (OP_SINGLE[p] != T_NONE) push_tok(OP_SINGLE[p]);
    start_scan(b);
  endfunction

  // one accepted source transfer
  function automatic void predict_lex(logic [7:0] b, logic eoi);
    int first;
    first  = lexemes_q.size();
    step_n = 0;
    if (mode == M_HALT) return;
    if (eoi) begin
      case (mode)
        M_OPER:   if (OP_SINGLE[pend_op] != T_NONE) push_tok(OP_SINGLE[pend_op]);
        M_IDENT:  push_tok(word_code());
        M_NUMBER: push_tok(dot_seen ? T_DEC : T_INT);
        M_STRING, M_ESCAPE: begin
          push_res(K_ERROR, 7'd0, 8'h00, tok_line, tok_col, E_STRING);
          mode = M_HALT;
        end
        M_BLOCKCMT: begin
          push_res(K_ERROR, 7'd0, 8'h00, tok_line, tok_col, E_COMMENT);
          mode = M_HALT;
        end
        default: ;
      endcase
      if (mode != M_HALT) begin
        push_res(K_TOKEN, T_END, 8'h00, cur_line, cur_col, 2'd0);
        clear_scan();
      end
    end else begin
      case (mode)
        M_START: start_scan(b);
        M_OPER:  oper_scan(b);
        M_IDENT: begin
          if (alpha(b) || digit(b) || b == "_") begin
            win_add(b); push_text(b); advance(b);
          end else begin
            push_tok(word_code()); mode = M_START; start_scan(b);
          end
        end
        M_NUMBER: begin
          if (digit(b) || (b == "." && !dot_seen)) begin
            if (b == ".") dot_seen = 1;
            push_text(b); advance(b);
          end else begin
            push_tok(dot_seen ? T_DEC : T_INT); mode = M_START; start_scan(b);
          end
        end
        M_STRING: begin
          advance(b);
          if (b == "\"") begin
            push_tok(T_STR); mode = M_START;
          end else if (b == "\\") begin
            mode = M_ESCAPE;
          end else begin
            push_text(b);
          end
        end
        M_ESCAPE: begin
          advance(b);
          push_text(b == "n" ? 8'h0A : b == "t" ? 8'h09 : b == "r" ? 8'h0D : b);
          mode = M_STRING;
        end
        M_LINECMT: begin
          advance(b);
          if (b == 8'h0A) mode = M_START;
        end
        M_BLOCKCMT: begin
          advance(b);
          if (star && b == "/") begin
            star = 0; mode = M_START;
          end else begin
            star = (b == "*");
          end
        end
        default: mode = M_HALT;
      endcase
    end
    if (lexemes_q.size() > first) lexemes_q[lexemes_q.size() - 1].last_of_run = 1'b1;
  endfunction

  initial begin
    clear_scan();
    mismatches = 0;
  end

  always @(posedge clk) begin
    lex_item_t want;
    if (!rst_n) begin
      clear_scan();
      lexemes_q.delete();
    end else begin
      if (in_valid && in_ready) predict_lex(in_data.byte_value, in_data.end_of_input);
      if (out_valid && out_ready) begin
        if (lexemes_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %p at %0t", out_data, $realtime);
        end else begin
          want = lexemes_q.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: expected %p actual %p", $realtime, want, out_data);
          end
        end
      end
    end
    awaited = lexemes_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// tokenizer testbench: directed and random source text with random idling
// ----------------------------------------------------------------------------
module tb_top;
  import sct_pkg::*;
  import tb_sct_types_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches;
  int   awaited;
  bit   calm = 1'b0;   // no idling on either side while set
  int   sent = 0;

  sct_stream_if #(.payload_t(in_item_t))  in_ch ();
  sct_stream_if #(.payload_t(out_item_t)) out_ch ();

  source_code_tokenizer i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  sct_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side stalls about a quarter of the time
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 24);
  end

  // one source transfer, with an occasional idle gap before it
  task automatic put_byte(logic [7:0] b, logic eoi);
    if (!calm && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{end_of_input: eoi, byte_value: b};
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sent++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
  endtask

  task automatic put_end();
    put_byte(8'($urandom), 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] letter();
    int r;
    r = $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  // one random lexeme, maybe followed by a separator
  task automatic put_piece();
    string ops [] = '{"/", "/=", "=", "==", "=>", "!", "!=", ">", ">=", "<", "<=",
                      "+", "+=", "-", "-=", "->", "*", "*=", "%", "%=", "&&", "||",
                      "&", "|", ".", "?", ":", ";", "{", "}", "(", ")", "[", "]"};
    int kind;
    int n;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 20) begin
      n = $urandom_range(KwCount - 1);
      for (int j = 0; j < KW_LEN[n]; j++) put_byte(KW_CHARS[n][j], 1'b0);
    end else if (kind < 35) begin
      b = letter();
      put_byte((b >= "0" && b <= "9") ? 8'("q") : b, 1'b0);
      n = ($urandom_range(9) == 0) ? $urandom_range(14, 8) : $urandom_range(4);
      repeat (n) put_byte(letter(), 1'b0);
    end else if (kind < 50) begin
      repeat ($urandom_range(4, 1)) put_byte(8'("0" + $urandom_range(9)), 1'b0);
      if ($urandom_range(2) == 0) begin
        put_byte(".", 1'b0);
        repeat ($urandom_range(3)) put_byte(8'("0" + $urandom_range(9)), 1'b0);
      end
    end else if (kind < 62) begin
      put_byte("\"", 1'b0);
      repeat ($urandom_range(6)) begin
        if ($urandom_range(4) == 0) begin
          put_byte("\\", 1'b0);
          put_byte(($urandom_range(1) == 0) ? 8'($urandom) : "n", 1'b0);
        end else begin
          do b = 8'($urandom); while (b == "\"" || b == "\\");
          put_byte(b, 1'b0);
        end
      end
      put_byte("\"", 1'b0);
    end else if (kind < 85) begin
      put_text(ops[$urandom_range(ops.size() - 1)]);
      put_byte(" ", 1'b0);   // keeps a following piece from joining the operator
      return;
    end else if (kind < 91) begin
      put_text("//");
      repeat ($urandom_range(5)) begin
        do b = 8'($urandom); while (b == 8'h0A);
        put_byte(b, 1'b0);
      end
      put_byte(8'h0A, 1'b0);
    end else if (kind < 96) begin
      put_text("/*");
      repeat ($urandom_range(6)) begin
        do b = 8'($urandom); while (b == "/");
        put_byte(b, 1'b0);
      end
      put_text("*/");
    end else begin
      // noise: bare whitespace
      put_byte(8'($urandom_range(13, 9)), 1'b0);
    end
    case ($urandom_range(5))
      0: put_byte(" ", 1'b0);
      1: put_byte(8'h0A, 1'b0);
      2: put_byte(8'($urandom_range(13, 9)), 1'b0);
      default: ;
    endcase
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keywords, long words, numbers, escapes, every operator
    put_text("true false contract contracts Ok x_9 _ 12 3.5 1.2.3 ");
    put_text("\"a\\n\\t\\r\\q\\\"");
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_text("\"\n/ /= = == => ! != > >= < <= + += - -= -> * *= % %= && || & | ");
    put_text(".?:;{}()[] // note\n /* a*b **/ x-");
    put_end();
    put_text("abc");
    put_end();
    put_end();

    // sender holds off until every pending result is back
    drain();

    // random sources, each closed by an end marker
    for (int k = 0; sent < 1200; k++) begin
      calm = (k >= 5 && k < 10);
      repeat ($urandom_range(12, 1)) put_piece();
      put_end();
    end
    calm = 1'b0;

    // a single error halts the block for the rest of the run
    case ($urandom_range(2))
      0: put_text("a ,");
      1: begin
        put_text("\"ab");
        put_end();
      end
      default: begin
        put_text("/* x");
        put_end();
      end
    endcase
    put_text("ab 1");
    put_end();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/sct_pkg.sv
design/sct_stream_if.sv
design/sct_kw_match.sv
design/sct_scan.sv
design/sct_out_buf.sv
design/source_code_tokenizer.sv
sim/tb_sct_types_pkg.sv
sim/sct_checker.sv
sim/tb_top.sv
